FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold whenever ante holds, sampled on i_clk outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// expr must never hold.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: hw/rtl/sbsh_pkg.sv
// Package with SHA-256 constants, round functions and controller/datapath types.
`timescale 1ns / 1ps

package sbsh_pkg;

    localparam logic [5:0] FILL_FULL = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd56;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [2:0] LAST_IDX  = 3'd7;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam logic [31:0] C_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] C_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {
        BYTE_IN,
        BYTE_PAD,
        BYTE_ZERO,
        BYTE_LEN
    } t_byte_sel;

    typedef struct packed {
        logic       push;
        t_byte_sel  byte_sel;
        logic       count_inc;
        logic       load_vars;
        logic       round_en;
        logic [5:0] round;
        logic       final_add;
        logic       clear_msg;
        logic [2:0] len_idx;
        logic [2:0] out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_dp_sts;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: hw/rtl/sbsh_dp.sv
// Datapath: block shift line, message schedule window, round logic, chain hash, counters.
`timescale 1ns / 1ps

module sbsh_dp import sbsh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_dp_sts     o_sts,
    output logic [31:0] o_digest_word
);

    logic [15:0][31:0] r_blk;
    logic [31:0]       r_chain [8];
    logic [31:0]       r_v [8];
    logic [5:0]        r_fill;
    logic [60:0]       r_count;

    logic [511:0]      w_flat;
    logic [7:0][7:0]   w_len;
    logic [7:0]        w_byte;
    logic [31:0]       w_new;
    logic [31:0]       w_t1;
    logic [31:0]       w_t2;
    logic [31:0]       w_ch;
    logic [31:0]       w_maj;

    assign w_flat = r_blk;
    assign w_len  = {r_count, 3'b000};

    always_comb begin
        unique case (i_cmd.byte_sel)
            BYTE_IN:   w_byte = i_data_byte;
            BYTE_PAD:  w_byte = PAD_BYTE;
            BYTE_ZERO: w_byte = 8'h00;
            BYTE_LEN:  w_byte = w_len[~i_cmd.len_idx];
            default:   w_byte = 8'h00;
        endcase
    end

    assign w_new = sml1(r_blk[1]) + r_blk[6] + sml0(r_blk[14]) + r_blk[15];
    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1  = r_v[7] + big1(r_v[4]) + w_ch + C_K[i_cmd.round] + r_blk[15];
    assign w_t2  = big0(r_v[0]) + w_maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_blk <= {w_flat[503:0], w_byte};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[14:0], w_new};
        end
        if (i_cmd.load_vars) begin
            r_v <= r_chain;
        end else if (i_cmd.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= C_IV;
            r_fill  <= '0;
            r_count <= '0;
        end else if (i_cmd.clear_msg) begin
            r_chain <= C_IV;
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.count_inc) begin
                r_count <= r_count + 61'd1;
            end
            if (i_cmd.final_add) begin
                for (int j = 0; j < 8; j++) begin
                    r_chain[j] <= r_chain[j] + r_v[j];
                end
            end
        end
    end

    assign o_sts.fill    = r_fill;
    assign o_digest_word = r_chain[i_cmd.out_idx];

endmodule

FILE: hw/rtl/sbsh_ctrl.sv
// Controller: sequences byte intake, padding, compression rounds and digest output.
`timescale 1ns / 1ps

module sbsh_ctrl import sbsh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_req_type,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_word_index,
    output logic       o_last_word,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_ROUND,
        S_FINAL,
        S_OUT
    } t_state;

    t_state     r_state;
    logic [5:0] r_round;
    logic [2:0] r_len_idx;
    logic [2:0] r_out_idx;
    logic       r_finish;
    logic       r_len_done;

    logic       w_full;

    assign w_full = (i_sts.fill == FILL_FULL);

    always_comb begin
        o_cmd          = '0;
        o_cmd.byte_sel = BYTE_IN;
        o_cmd.round    = r_round;
        o_cmd.len_idx  = r_len_idx;
        o_cmd.out_idx  = r_out_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.count_inc = !i_req_type;
                    o_cmd.byte_sel  = i_req_type ? BYTE_PAD : BYTE_IN;
                    o_cmd.load_vars = w_full;
                end
            end
            S_PAD_ZERO: begin
                if (i_sts.fill != FILL_LEN) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.byte_sel  = BYTE_ZERO;
                    o_cmd.load_vars = w_full;
                end
            end
            S_PAD_LEN: begin
                o_cmd.push      = 1'b1;
                o_cmd.byte_sel  = BYTE_LEN;
                o_cmd.load_vars = w_full;
            end
            S_ROUND:  o_cmd.round_en  = 1'b1;
            S_FINAL:  o_cmd.final_add = 1'b1;
            S_OUT:    o_cmd.clear_msg = !i_out_stall && (r_out_idx == LAST_IDX);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_round    <= '0;
            r_len_idx  <= '0;
            r_out_idx  <= '0;
            r_finish   <= 1'b0;
            r_len_done <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_finish <= i_req_type;
                        r_round  <= '0;
                        if (w_full) begin
                            r_state <= S_ROUND;
                        end else if (i_req_type) begin
                            r_state <= S_PAD_ZERO;
                        end
                    end
                end
                S_PAD_ZERO: begin
                    r_round   <= '0;
                    r_len_idx <= '0;
                    if (i_sts.fill == FILL_LEN) begin
                        r_state <= S_PAD_LEN;
                    end else if (w_full) begin
                        r_state <= S_ROUND;
                    end
                end
                S_PAD_LEN: begin
                    r_len_idx <= r_len_idx + 3'd1;
                    r_round   <= '0;
                    if (r_len_idx == LAST_IDX) begin
                        r_len_done <= 1'b1;
                        r_state    <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == LAST_ROUND) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_out_idx <= '0;
                    if (!r_finish) begin
                        r_state <= S_IDLE;
                    end else if (r_len_done) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PAD_ZERO;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == LAST_IDX) begin
                            r_finish   <= 1'b0;
                            r_len_done <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_word_index = r_out_idx;
    assign o_last_word  = (r_out_idx == LAST_IDX);

endmodule

FILE: hw/rtl/sha256_byte_stream_hasher.sv
// Top level of the byte-serial SHA-256 hasher: controller plus datapath.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_req_type, i_data_byte
//  out     | output    | o_out_valid / i_out_stall  | o_digest_word, o_word_index, o_last_word
//
// A message byte is taken while idle; the byte that completes a 64-byte block then starts
// compression (64 rounds on the single round unit, then the chain add) with input stalled.
// A finish item appends the padding bytes, compresses once or twice, then shows 8 words.
// Reset is synchronous and active low; the block is ready right after it.
// Input is stalled whenever the block is busy; a stalled output word holds its value.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher import sbsh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    `include "assert_macros.svh"

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sbsh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    sbsh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_data_byte),
        .o_sts         (w_sts),
        .o_digest_word (o_digest_word)
    );

    `ASSERT_NEVER(a_out_while_ready, o_out_valid && !o_in_stall, "output valid while input ready")
    `ASSERT_NEXT(a_finish_busy, i_in_valid && !o_in_stall && i_req_type, o_in_stall, "finish item did not stall input")
    `ASSERT_NEXT(a_last_ends, o_out_valid && !i_out_stall && o_last_word, !o_out_valid, "output continued past last word")

endmodule

FILE: tb/tb_sha256_byte_stream_hasher.sv
// Self-checking testbench for the byte-serial SHA-256 hasher with random flow control.
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher;

    localparam logic REQ_BYTE   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;
    localparam int   TAIL_ITEMS = 50;
    localparam int   HOLD_AFTER = 30;
    localparam int   HOLD_CYCLES = 600;
    localparam int   DRAIN_CYCLES = 200;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       req;
        logic [7:0] data;
    } t_hash_req;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_BYTE;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    t_hash_req    pending_reqs [$];
    t_digest_word expected_words [$];
    int           mismatches = 0;
    int           reqs_taken = 0;
    int           in_gap = 0;
    int           out_gap = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    bit           stim_loaded = 1'b0;

    logic [31:0] chain_words [8];
    logic [7:0]  chunk_bytes [64];
    int unsigned chunk_fill;
    logic [60:0] msg_bytes;

    sha256_byte_stream_hasher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_data_byte   (data_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_digest_word (digest_word),
        .o_word_index  (word_index),
        .o_last_word   (last_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_chunk();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {chunk_bytes[4*i], chunk_bytes[4*i+1], chunk_bytes[4*i+2],
                    chunk_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = chain_words[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        chunk_bytes[chunk_fill] = b;
        chunk_fill++;
        if (chunk_fill == 64) begin
            compress_chunk();
            chunk_fill = 0;
        end
    endtask

    task automatic clear_hash_state();
        for (int i = 0; i < 8; i++) chain_words[i] = HASH_IV[i];
        chunk_fill = 0;
        msg_bytes = '0;
    endtask

    task automatic hash_item(input t_hash_req r);
        logic [63:0]  bit_len;
        t_digest_word d;
        if (r.req == REQ_BYTE) begin
            msg_bytes = msg_bytes + 61'd1;
            absorb_byte(r.data);
        end else begin
            bit_len = {msg_bytes, 3'b000};
            absorb_byte(8'h80);
            while (chunk_fill != 56) absorb_byte(8'h00);
            for (int i = 7; i >= 0; i--) absorb_byte(bit_len[8*i +: 8]);
            for (int i = 0; i < 8; i++) begin
                d.word = chain_words[i];
                d.idx  = i[2:0];
                d.last = (i == 7);
                expected_words.push_back(d);
            end
            clear_hash_state();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns digest check: %s got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_message(input int len, input logic [7:0] finish_data);
        t_hash_req r;
        for (int i = 0; i < len; i++) begin
            r.req  = REQ_BYTE;
            r.data = 8'($urandom_range(0, 255));
            pending_reqs.push_back(r);
        end
        r.req  = REQ_FINISH;
        r.data = finish_data;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        t_hash_req r;
        r.req  = REQ_BYTE;
        r.data = b;
        pending_reqs.push_back(r);
    endtask

    function automatic bit in_tail();
        return stim_loaded && (pending_reqs.size() < TAIL_ITEMS);
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_hash_req r;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                r.req  = req_type;
                r.data = data_byte;
                hash_item(r);
                reqs_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    if (!in_tail() && $urandom_range(0, 7) == 0) begin
                        in_gap = $urandom_range(1, 19) - 1;
                        in_valid <= 1'b0;
                    end else begin
                        r = pending_reqs.pop_front();
                        in_valid  <= 1'b1;
                        req_type  <= r.req;
                        data_byte <= r.data;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_digest_word d;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    flag_mismatch("word with no digest pending", digest_word, 32'h0);
                end else begin
                    d = expected_words.pop_front();
                    if (digest_word !== d.word) flag_mismatch("digest_word", digest_word, d.word);
                    if (word_index !== d.idx) begin
                        flag_mismatch("word_index", 32'(word_index), 32'(d.idx));
                    end
                    if (last_word !== d.last) begin
                        flag_mismatch("last_word", 32'(last_word), 32'(d.last));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!hold_done && reqs_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 19) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int edge_lens [4];
        int len;
        edge_lens = '{55, 56, 63, 64};
        clear_hash_state();

        queue_message(0, 8'hff);
        queue_byte(8'h00);
        queue_byte(8'hff);
        queue_message(0, 8'h00);
        queue_byte(8'h61);
        queue_byte(8'h62);
        queue_byte(8'h63);
        queue_message(0, 8'h5a);
        queue_message(0, 8'ha5);
        queue_byte(8'h80);
        queue_message(0, 8'h01);

        for (int k = 0; pending_reqs.size() < 380; k++) begin
            len = (k < 4) ? edge_lens[k] : $urandom_range(0, 30);
            queue_message(len, 8'($urandom_range(0, 255)));
        end
        stim_loaded = 1'b1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
